/* src/lrup_pkg.sv */
`default_nettype none

package lrup_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam int PAGE_IN_W  = 16;
  localparam int CFG_W      = 4;
  localparam int COUNT_W    = 32;
  localparam int SLOT_W     = 3;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 1;
  localparam int OUT_PAD_W  = OUT_DATA_W - (SLOT_W + 1 + PAGE_IN_W + 2 * COUNT_W);

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_TOUCH,
    ST_TOUCH_END,
    ST_DONE
  } lrup_state_t;

  // Per-frame results of the shared compare unit
  typedef struct packed {
    logic page_hit;
    logic empty;
    logic older;
    logic ages;
  } lrup_flags_t;

endpackage

`default_nettype wire

/* src/lrup_ram.sv */
`default_nettype none

module lrup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* src/lrup_frame_unit.sv */
`default_nettype none

module lrup_frame_unit
  import lrup_pkg::*;
#(
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  parameter int RANK_W    = 4
) (
  input  wire logic                 entry_valid,
  input  wire logic [PAGE_BITS-1:0] entry_page,
  input  wire logic [PAGE_BITS-1:0] req_page,
  input  wire logic [RANK_W-1:0]    entry_rank,
  input  wire logic [RANK_W-1:0]    best_rank,
  input  wire logic [RANK_W-1:0]    ref_rank,
  output lrup_flags_t               flags,
  output logic      [RANK_W-1:0]    rank_inc
);

  // One frame per cycle: match, empty test, LRU compare, and aging test
  always_comb begin
    flags.page_hit = entry_valid && (entry_page == req_page);
    flags.empty    = !entry_valid;
    flags.older    = entry_rank > best_rank;
    flags.ages     = entry_valid && (entry_rank < ref_rank);
    rank_inc       = entry_rank + RANK_W'(1);
  end

endmodule

`default_nettype wire

/* src/lru_page_replacement.sv */
`default_nettype none

// LRU page replacement engine. Each input word carries one page reference; each
// result word reports hit or fault, the frame hit or filled, the replaced page if
// any, and saturating fault and hit totals. The table holds FRAMES frames, of
// which the first frames_in_use (clamped to 1..FRAMES) are searched and replaced.
// One reference keeps in_tready low from its acceptance until its result word is
// loaded into the output register, and that load waits while the previous result
// word still waits in the output register: a single compare unit visits one frame
// per cycle, first sweeping the active frames through the page and rank RAM read
// ports to find the hit, the first empty frame and the least recently used frame,
// then sweeping all frames to age the recency ranks and install the new page. A
// finished result waits in the output register while the next reference is worked
// on. No clearing pass is needed after reset; frame valid bits are cleared at once.
module lru_page_replacement
  import lrup_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [15:0] page_number
  input  wire logic [PAGE_IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] frame_slot, [3] evicted_valid, [19:4] evicted_page,
  // [51:20] fault_total, [83:52] hit_total, [87:84] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [0] ref_miss
  output logic [OUT_USER_W-1:0]      out_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RW = $clog2(FRAMES + 1);

  lrup_state_t state_r, state_nxt;

  logic [CFG_W-1:0]      frames_in_use_r;
  logic [IW-1:0]         cnt_r, cnt_nxt;
  logic [IW-1:0]         pidx_r, pidx_nxt;
  logic                  pend_r, pend_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic                  found_r, found_nxt;
  logic [IW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [RW-1:0]         hit_rank_r, hit_rank_nxt;
  logic                  empty_found_r, empty_found_nxt;
  logic [IW-1:0]         empty_idx_r, empty_idx_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;
  logic [RW-1:0]         best_rank_r, best_rank_nxt;
  logic [PAGE_BITS-1:0]  best_page_r, best_page_nxt;
  logic [FRAMES-1:0]     valid_r, valid_nxt;
  logic [COUNT_W-1:0]    fault_cnt_r, fault_cnt_nxt;
  logic [COUNT_W-1:0]    hit_cnt_r, hit_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic [7:0]            cfg_ext;
  logic [RW-1:0]         active_n;
  logic [IW-1:0]         last_scan;
  logic [IW-1:0]         slot_sel;
  logic [RW-1:0]         ref_rank;
  logic                  is_slot;
  logic                  scan_proc;
  logic                  touch_proc;
  logic [31:0]           in_ext;
  logic [31:0]           ev_ext;
  logic [7:0]            slot_ext;
  logic                  evict;

  logic [PAGE_BITS-1:0]  page_rdata;
  logic [RW-1:0]         rank_rdata;
  logic                  page_we;
  logic                  rank_we;
  logic [RW-1:0]         rank_wdata;
  lrup_flags_t           flags;
  logic [RW-1:0]         rank_inc;

  // Clamp the register to 1..FRAMES
  always_comb begin
    cfg_ext = 8'(frames_in_use_r);
    if (cfg_ext == 8'd0) begin
      active_n = RW'(1);
    end else if (cfg_ext > 8'(FRAMES)) begin
      active_n = RW'(FRAMES);
    end else begin
      active_n = RW'(cfg_ext);
    end
    last_scan = IW'(active_n - RW'(1));
  end

  // Replacement choice, stable once the scan sweep has finished
  always_comb begin
    if (found_r) begin
      slot_sel = hit_idx_r;
      ref_rank = hit_rank_r;
    end else if (empty_found_r) begin
      slot_sel = empty_idx_r;
      ref_rank = RW'(FRAMES);
    end else begin
      slot_sel = best_idx_r;
      ref_rank = best_rank_r;
    end
    evict = !found_r && !empty_found_r;
  end

  assign scan_proc  = pend_r && ((state_r == ST_SCAN) || (state_r == ST_SCAN_END));
  assign touch_proc = pend_r && ((state_r == ST_TOUCH) || (state_r == ST_TOUCH_END));
  assign is_slot    = (pidx_r == slot_sel);
  assign in_ext     = 32'(in_tdata);

  assign page_we    = (state_r == ST_TOUCH) && (cnt_r == '0);
  assign rank_we    = touch_proc && (is_slot || flags.ages);
  assign rank_wdata = is_slot ? '0 : rank_inc;

  lrup_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (slot_sel),
    .wdata (page_r),
    .raddr (cnt_r),
    .rdata (page_rdata)
  );

  lrup_ram #(
    .WIDTH (RW),
    .DEPTH (FRAMES)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (pidx_r),
    .wdata (rank_wdata),
    .raddr (cnt_r),
    .rdata (rank_rdata)
  );

  lrup_frame_unit #(
    .PAGE_BITS (PAGE_BITS),
    .RANK_W    (RW)
  ) u_frame_unit (
    .entry_valid (valid_r[pidx_r]),
    .entry_page  (page_rdata),
    .req_page    (page_r),
    .entry_rank  (rank_rdata),
    .best_rank   (best_rank_r),
    .ref_rank    (ref_rank),
    .flags       (flags),
    .rank_inc    (rank_inc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      pend_r          <= 1'b0;
      valid_r         <= '0;
      fault_cnt_r     <= '0;
      hit_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      frames_in_use_r <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        frames_in_use_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    pidx_r        <= pidx_nxt;
    page_r        <= page_nxt;
    found_r       <= found_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_rank_r    <= hit_rank_nxt;
    empty_found_r <= empty_found_nxt;
    empty_idx_r   <= empty_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_rank_r   <= best_rank_nxt;
    best_page_r   <= best_page_nxt;
    out_data_r    <= out_data_nxt;
    out_user_r    <= out_user_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    pidx_nxt        = cnt_r;
    pend_nxt        = 1'b0;
    page_nxt        = page_r;
    found_nxt       = found_r;
    hit_idx_nxt     = hit_idx_r;
    hit_rank_nxt    = hit_rank_r;
    empty_found_nxt = empty_found_r;
    empty_idx_nxt   = empty_idx_r;
    best_idx_nxt    = best_idx_r;
    best_rank_nxt   = best_rank_r;
    best_page_nxt   = best_page_r;
    valid_nxt       = valid_r;
    fault_cnt_nxt   = fault_cnt_r;
    hit_cnt_nxt     = hit_cnt_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;
    in_tready       = 1'b0;
    ev_ext          = 32'(best_page_r);
    slot_ext        = 8'(slot_sel);

    // Drop the held word once it is taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Fold one frame's compare results into the scan registers
    if (scan_proc) begin
      if (flags.page_hit && !found_r) begin
        found_nxt    = 1'b1;
        hit_idx_nxt  = pidx_r;
        hit_rank_nxt = rank_rdata;
      end
      if (flags.empty && !empty_found_r) begin
        empty_found_nxt = 1'b1;
        empty_idx_nxt   = pidx_r;
      end
      if ((pidx_r == '0) || flags.older) begin
        best_idx_nxt  = pidx_r;
        best_rank_nxt = rank_rdata;
        best_page_nxt = page_rdata;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          page_nxt        = in_ext[PAGE_BITS-1:0];
          found_nxt       = 1'b0;
          empty_found_nxt = 1'b0;
          cnt_nxt         = '0;
          state_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_nxt = 1'b1;
        if (cnt_r == last_scan) begin
          state_nxt = ST_SCAN_END;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_SCAN_END: begin
        cnt_nxt   = '0;
        state_nxt = ST_TOUCH;
      end
      ST_TOUCH: begin
        pend_nxt = 1'b1;
        if (cnt_r == IW'(FRAMES - 1)) begin
          state_nxt = ST_TOUCH_END;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_TOUCH_END: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          valid_nxt[slot_sel] = 1'b1;
          if (found_r) begin
            if (hit_cnt_r != '1) begin
              hit_cnt_nxt = hit_cnt_r + COUNT_W'(1);
            end
          end else if (fault_cnt_r != '1) begin
            fault_cnt_nxt = fault_cnt_r + COUNT_W'(1);
          end
          out_valid_nxt = 1'b1;
          out_user_nxt  = OUT_USER_W'(!found_r);
          out_data_nxt  = {
            {OUT_PAD_W{1'b0}},
            hit_cnt_nxt,
            fault_cnt_nxt,
            evict ? ev_ext[PAGE_IN_W-1:0] : {PAGE_IN_W{1'b0}},
            evict,
            slot_ext[SLOT_W-1:0]
          };
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

/* src/lrup_checker.sv */
`default_nettype none

module lrup_checker
  import lrup_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word pending after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // One reference at a time: busy after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");

  // A replacement only happens on a fault
  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tuser[0])
    else $error("eviction reported on a hit");

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (.*);

`default_nettype wire
